FILE: rtl/azat_pkg.sv
// Package for the full-circle azimuth block: fixed-point formats, the stage
// record types and the arctangent constants, all settled at elaboration.
// Depends on nothing.
package azat_pkg;

  localparam logic [63:0] ANG_ONE    = 64'd1 << 61;  // 1.0 in Q3.61
  localparam int          MAX_STAGES = 62;
  localparam int          NORM_BIT   = 60;
  localparam logic [32:0] AZ_MAX     = 33'd3373259426;
  localparam logic [64:0] ROUND_HALF = 65'h8000_0000;

  typedef logic signed [63:0] vec_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
  } cordic_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic ax_zero;
    logic ay_zero;
  } quad_t;

  // Restoring long division, only ever evaluated while building constants.
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in Q3.61 by the power series, each term truncated.
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] n2;
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    p    = udiv(ANG_ONE, n);
    n2   = (n < (64'd1 << 31)) ? n * n : 64'd0;
    sum  = '0;
    stop = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (!stop) begin
        if (p == 64'd0) begin
          stop = 1'b1;
        end else begin
          term = udiv(p, 64'(2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
          if (n2 == 64'd0) begin
            stop = 1'b1;
          end else begin
            p = udiv(p, n2);
          end
        end
      end
    end
    return sum;
  endfunction

  // Machin's formula gives pi/4.
  localparam logic [63:0] QUARTER       = (atan_inv(64'd5) << 2) - atan_inv(64'd239);
  localparam logic [63:0] HALF_PI       = QUARTER << 1;
  localparam logic [63:0] PI            = QUARTER << 2;
  localparam logic [63:0] THREE_HALF_PI = PI + HALF_PI;
  localparam logic [63:0] TWO_PI        = PI << 1;
  localparam logic [31:0] HALF_PI_Q     = 32'(({1'b0, HALF_PI} + ROUND_HALF) >> 32);

  // Rotation angle of one CORDIC stage; the first stage turns by pi/4.
  function automatic logic [63:0] atan_entry(input int i);
    if (i == 0) begin
      return QUARTER;
    end
    return atan_inv(64'd1 << i);
  endfunction

endpackage

FILE: rtl/azimuth_atan2_full_circle.sv
// Top level of the full-circle azimuth block: an unrolled CORDIC vectoring
// pipeline that turns a signed offset pair into an angle in [0, 2*pi).
// Depends on azat_pkg.
//
// Usage: drive delta_x and delta_y with start high for one cycle per beat.
// A beat is taken at every rising edge where start is high and busy is low;
// busy stays low, so a new pair may be given on every cycle.
// The angle leaves on azimuth (unsigned Q3.29 radians) with done high for
// exactly one cycle, in the order the pairs were taken. The receiver cannot
// hold results off and none is needed: one result leaves per cycle at most.
// The path is registered after sign and magnitude, after the leading-one search
// by byte, after the normalising shift, after each CORDIC micro-rotation, after
// the quadrant mapping and after rounding.
// Throughput is one pair per cycle, set by the single-rotation stages.
// Synchronous reset empties the pipeline: beats in flight are dropped and no
// done pulse follows for them. No other state is held.
module azimuth_atan2_full_circle #(
  parameter int INPUT_WIDTH   = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [INPUT_WIDTH-1:0] delta_x,
  input  logic signed [INPUT_WIDTH-1:0] delta_y,
  output logic                          done,
  output logic        [31:0]            azimuth
);

  localparam int NumStages = (CORDIC_STAGES < azat_pkg::MAX_STAGES) ?
                             CORDIC_STAGES : azat_pkg::MAX_STAGES;
  localparam int Latency   = NumStages + 5;

  assign busy = 1'b0;

  // Sign and magnitude.
  logic [INPUT_WIDTH-1:0] mag_x;
  logic [INPUT_WIDTH-1:0] mag_y;
  logic [63:0]            dec_ax;
  logic [63:0]            dec_ay;
  azat_pkg::quad_t        dec_q;
  logic                   dec_vld;

  assign mag_x = delta_x[INPUT_WIDTH-1] ? $unsigned(-delta_x) : $unsigned(delta_x);
  assign mag_y = delta_y[INPUT_WIDTH-1] ? $unsigned(-delta_y) : $unsigned(delta_y);

  always_ff @(posedge clk) begin
    dec_ax          <= 64'(mag_x);
    dec_ay          <= 64'(mag_y);
    dec_q.nx        <= delta_x[INPUT_WIDTH-1];
    dec_q.ny        <= delta_y[INPUT_WIDTH-1];
    dec_q.ax_zero   <= (delta_x == '0);
    dec_q.ay_zero   <= (delta_y == '0);
  end

  // Leading one, first per byte.
  logic [63:0]      both;
  logic [7:0]       byte_nz;
  logic [7:0][2:0]  byte_pos;
  logic [63:0]      grp_ax;
  logic [63:0]      grp_ay;
  azat_pkg::quad_t  grp_q;
  logic [7:0]       grp_nz;
  logic [7:0][2:0]  grp_pos;
  logic             grp_vld;

  assign both = dec_ax | dec_ay;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      byte_nz[g]  = |both[g*8 +: 8];
      byte_pos[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (both[g*8 + b]) begin
          byte_pos[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_ax  <= dec_ax;
    grp_ay  <= dec_ay;
    grp_q   <= dec_q;
    grp_nz  <= byte_nz;
    grp_pos <= byte_pos;
  end

  // Then the byte, and the shift that puts the top bit at bit 60.
  logic [5:0]        msb;
  logic [63:0]       norm_x;
  logic [63:0]       norm_y;
  azat_pkg::cordic_t stg [NumStages+1];
  azat_pkg::quad_t   stg_q [NumStages+1];
  logic              vld [NumStages+1];

  always_comb begin
    msb = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) begin
        msb = {3'(g), grp_pos[g]};
      end
    end
    if (msb > 6'(azat_pkg::NORM_BIT)) begin
      norm_x = grp_ax >> (msb - 6'(azat_pkg::NORM_BIT));
      norm_y = grp_ay >> (msb - 6'(azat_pkg::NORM_BIT));
    end else begin
      norm_x = grp_ax << (6'(azat_pkg::NORM_BIT) - msb);
      norm_y = grp_ay << (6'(azat_pkg::NORM_BIT) - msb);
    end
  end

  always_ff @(posedge clk) begin
    stg[0].x <= $signed(norm_x);
    stg[0].y <= $signed(norm_y);
    stg[0].z <= '0;
    stg_q[0] <= grp_q;
  end

  // One micro-rotation per stage, driving y towards zero.
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam logic [63:0] Angle = azat_pkg::atan_entry(s);
    azat_pkg::vec_t xs;
    azat_pkg::vec_t ys;

    assign xs = stg[s].x >>> s;
    assign ys = stg[s].y >>> s;

    always_ff @(posedge clk) begin
      if (!stg[s].y[63]) begin
        stg[s+1].x <= stg[s].x + ys;
        stg[s+1].y <= stg[s].y - xs;
        stg[s+1].z <= stg[s].z + $signed(Angle);
      end else begin
        stg[s+1].x <= stg[s].x - ys;
        stg[s+1].y <= stg[s].y + xs;
        stg[s+1].z <= stg[s].z - $signed(Angle);
      end
      stg_q[s+1] <= stg_q[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  // Clamp theta to [0, pi/2] and place it in its quadrant.
  azat_pkg::vec_t  z_last;
  azat_pkg::quad_t q_last;
  logic [63:0]     theta;
  logic [63:0]     ang;
  logic [63:0]     map_ang;
  logic            map_vld;

  assign z_last = stg[NumStages].z;
  assign q_last = stg_q[NumStages];

  always_comb begin
    if (q_last.ay_zero || z_last[63]) begin
      theta = '0;
    end else if ($unsigned(z_last) > azat_pkg::HALF_PI) begin
      theta = azat_pkg::HALF_PI;
    end else begin
      theta = $unsigned(z_last);
    end
    if (q_last.ax_zero) begin
      ang = (!q_last.ny && !q_last.ay_zero) ? azat_pkg::HALF_PI : azat_pkg::THREE_HALF_PI;
    end else if (!q_last.nx) begin
      ang = q_last.ny ? azat_pkg::TWO_PI - theta : theta;
    end else begin
      ang = q_last.ny ? azat_pkg::PI + theta : azat_pkg::PI - theta;
    end
  end

  always_ff @(posedge clk) begin
    map_ang <= ang;
  end

  // Round Q3.61 to Q3.29 and saturate just below two pi.
  logic [64:0] round_sum;
  logic [32:0] rounded;

  assign round_sum = {1'b0, map_ang} + azat_pkg::ROUND_HALF;
  assign rounded   = round_sum[64:32];

  always_ff @(posedge clk) begin
    azimuth <= (rounded > azat_pkg::AZ_MAX) ? azat_pkg::AZ_MAX[31:0] : rounded[31:0];
  end

  // Beat valid bits outside the CORDIC stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_vld <= 1'b0;
      grp_vld <= 1'b0;
      vld[0]  <= 1'b0;
      map_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      dec_vld <= start && !busy;
      grp_vld <= dec_vld;
      vld[0]  <= grp_vld;
      map_vld <= vld[NumStages];
      done    <= map_vld;
    end
  end

  // Every beat taken comes out after the fixed latency.
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("accepted beat did not produce a result");

  // No result appears without a beat taken the matching number of cycles before.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without a matching accepted beat");

  // A vector on the positive x axis has angle zero.
  a_pos_x_axis: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && delta_y == '0 && !delta_x[INPUT_WIDTH-1] && delta_x != '0)
      |-> ##Latency (done && azimuth == '0))
    else $error("positive x axis did not give zero");

  // A vector on the positive y axis has angle pi/2.
  a_pos_y_axis: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && delta_x == '0 && !delta_y[INPUT_WIDTH-1] && delta_y != '0)
      |-> ##Latency (done && azimuth == azat_pkg::HALF_PI_Q))
    else $error("positive y axis did not give pi/2");

  // Output range is held below two pi.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, azimuth} <= azat_pkg::AZ_MAX))
    else $error("azimuth above its largest code");

endmodule
